### rtl/spv_pkg.sv
// Shared types, constants and helper functions for the sample playback voice.
package spv_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT  = 3'd0,
    CFG_LOOPING       = 3'd1,
    CFG_STEREO_SOURCE = 3'd2,
    CFG_STEREO_OUTPUT = 3'd3,
    CFG_WIDE_SAMPLES  = 3'd4,
    CFG_MIN_SPEED     = 3'd5,
    CFG_MAX_SPEED     = 3'd6
  } cfg_idx_e;

  localparam logic       FUNC_LOAD  = 1'b0;
  localparam logic [7:0] PLAY_STOP  = 8'd64;
  localparam logic [7:0] PLAY_RUN   = 8'd192;

  localparam logic [14:0] RST_SAMPLE_COUNT = 15'd1;
  localparam logic [23:0] RST_SPEED        = 24'd65536;

  localparam logic [16:0] UNITY_GAIN  = 17'd32768;  // Q1.15 one
  localparam logic [16:0] UNITY_BLEND = 17'd65536;  // Q1.16 one

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_MIX,
    ST_WRAP,
    ST_EMIT
  } state_e;

  // Step of the multiply sequencer, named after the product it issues
  typedef enum logic [3:0] {
    MS_SPEED  = 4'd0,
    MS_PAN_X1 = 4'd1,
    MS_PAN_X2 = 4'd2,
    MS_PAN_Y1 = 4'd3,
    MS_PAN_Y2 = 4'd4,
    MS_MIX_X1 = 4'd5,
    MS_MIX_X2 = 4'd6,
    MS_MIX_Y1 = 4'd7,
    MS_MIX_Y2 = 4'd8,
    MS_FLUSH  = 4'd9
  } mix_step_e;

  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic        wide;
    logic        stereo_src;
    logic        stereo_out;
    logic [15:0] frac;
    logic [23:0] min_speed;
    logic [23:0] max_speed;
    logic [15:0] ctl;
    logic [15:0] pan;
  } mix_req_t;

  typedef struct packed {
    logic [23:0] speed;
    logic [15:0] left;
    logic [15:0] right;
  } mix_res_t;

  // 16-bit two's complement, or offset-binary byte scaled by 256
  function automatic logic [15:0] decode_half(input logic [15:0] half, input logic wide);
    if (wide) begin
      return half;
    end
    return {~half[7], half[6:0], 8'h00};
  endfunction

  // floor((a + b) / 2)
  function automatic logic [15:0] avg2(input logic [15:0] a, input logic [15:0] b);
    logic signed [16:0] s;
    s = $signed({a[15], a}) + $signed({b[15], b});
    return s[16:1];
  endfunction

endpackage

### rtl/spv_if.sv
// Valid/ready channel interfaces for tick/load items and output frames.
interface spv_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [13:0]        load_address;
  logic [15:0]        load_left;
  logic [15:0]        load_right;
  logic [7:0]         play_level;
  logic [15:0]        speed_control;
  logic signed [15:0] pan;

  modport source (
    output valid, func, load_address, load_left, load_right, play_level,
           speed_control, pan,
    input  ready
  );
  modport sink (
    input  valid, func, load_address, load_left, load_right, play_level,
           speed_control, pan,
    output ready
  );
endinterface

interface spv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic               playing;

  modport source (
    output valid, out_left, out_right, playing,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_right, playing,
    output ready
  );
endinterface

### rtl/sample_playback_voice.sv
// Top level of the sample playback voice: control sequencer, state and store.
// A load beat writes one 32-bit word (left in the low half) into the sample store
// when its address lies inside the store. A tick beat yields exactly one frame. Stop
// and middle levels, and the end of a non-looping sample, go from idle straight to
// the emit state and give a silent frame. A playing tick makes two reads of the single
// store read port, then ten steps of the one shared 25x18 multiplier (speed, four pan
// products, four blend products and a flush). With looping on, the bit-serial remainder
// unit makes two passes, W = max(15, log2(SAMPLE_DEPTH) + 1) being its width. The next
// beat is taken as soon as the frame sits in the output register.
module sample_playback_voice #(
  parameter int SAMPLE_DEPTH = 16384
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  spv_in_if.sink                         in_i,
  spv_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [spv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [spv_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int POS_W = $clog2(SAMPLE_DEPTH);
  localparam int DW    = (POS_W + 1 > 15) ? POS_W + 1 : 15;

  // configuration
  logic [14:0] sample_count_q;
  logic        looping_q;
  logic        stereo_source_q;
  logic        stereo_output_q;
  logic        wide_samples_q;
  logic [23:0] min_speed_q;
  logic [23:0] max_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q  <= spv_pkg::RST_SAMPLE_COUNT;
      looping_q       <= 1'b0;
      stereo_source_q <= 1'b0;
      stereo_output_q <= 1'b0;
      wide_samples_q  <= 1'b1;
      min_speed_q     <= spv_pkg::RST_SPEED;
      max_speed_q     <= spv_pkg::RST_SPEED;
    end else if (cfg_we_i) begin
      unique case (spv_pkg::cfg_idx_e'(cfg_index_i))
        spv_pkg::CFG_SAMPLE_COUNT:  sample_count_q  <= cfg_data_i[14:0];
        spv_pkg::CFG_LOOPING:       looping_q       <= cfg_data_i[0];
        spv_pkg::CFG_STEREO_SOURCE: stereo_source_q <= cfg_data_i[0];
        spv_pkg::CFG_STEREO_OUTPUT: stereo_output_q <= cfg_data_i[0];
        spv_pkg::CFG_WIDE_SAMPLES:  wide_samples_q  <= cfg_data_i[0];
        spv_pkg::CFG_MIN_SPEED:     min_speed_q     <= cfg_data_i;
        spv_pkg::CFG_MAX_SPEED:     max_speed_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective count
  logic [DW-1:0] cnt_raw;
  logic [DW-1:0] count;
  logic [DW-1:0] last;

  always_comb begin
    cnt_raw = (sample_count_q == '0) ? DW'(1) : DW'(sample_count_q);
    count   = (cnt_raw > DW'(SAMPLE_DEPTH)) ? DW'(SAMPLE_DEPTH) : cnt_raw;
    last    = count - DW'(1);
  end

  // state
  spv_pkg::state_e state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      frac_q, frac_d;
  logic [POS_W-1:0] cur_q, cur_d;
  logic [POS_W-1:0] nxt_q, nxt_d;
  logic [15:0]      ctl_q, ctl_d;
  logic [15:0]      pan_q, pan_d;
  logic [31:0]      word0_q, word0_d;
  logic [15:0]      res_left_q, res_left_d;
  logic [15:0]      res_right_q, res_right_d;
  logic             res_play_q, res_play_d;
  logic             out_valid_q, out_valid_d;
  logic [15:0]      out_left_q, out_left_d;
  logic [15:0]      out_right_q, out_right_d;
  logic             out_play_q, out_play_d;

  // store
  logic             ram_we;
  logic [DW-1:0]    load_addr;
  logic [POS_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  assign load_addr = DW'(in_i.load_address);
  assign ram_raddr = (state_q == spv_pkg::ST_RD0) ? cur_q : nxt_q;

  spv_ram #(
    .WIDTH (32),
    .DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_addr[POS_W-1:0]),
    .wdata_i ({in_i.load_right, in_i.load_left}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // remainder unit
  logic          rem_start;
  logic [DW-1:0] rem_dividend;
  logic          rem_done;
  logic [DW-1:0] rem_val;
  logic [DW-1:0] rem_inc;

  spv_rem #(
    .W (DW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (count),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // arithmetic unit
  logic              mix_start;
  spv_pkg::mix_req_t mix_req;
  logic              mix_done;
  spv_pkg::mix_res_t mix_res;

  always_comb begin
    mix_req.word0      = word0_q;
    mix_req.word1      = ram_rdata;
    mix_req.wide       = wide_samples_q;
    mix_req.stereo_src = stereo_source_q;
    mix_req.stereo_out = stereo_output_q;
    mix_req.frac       = frac_q;
    mix_req.min_speed  = min_speed_q;
    mix_req.max_speed  = max_speed_q;
    mix_req.ctl        = ctl_q;
    mix_req.pan        = pan_q;
  end

  spv_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mix_start),
    .req_i   (mix_req),
    .done_o  (mix_done),
    .res_o   (mix_res)
  );

  logic [24:0]   total;
  logic [DW-1:0] tot;

  always_comb begin
    rem_inc = rem_val + DW'(1);
    total   = {1'b0, mix_res.speed} + 25'(frac_q);
    tot     = DW'(cur_q) + DW'(total[24:16]);
  end

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    frac_d       = frac_q;
    cur_d        = cur_q;
    nxt_d        = nxt_q;
    ctl_d        = ctl_q;
    pan_d        = pan_q;
    word0_d      = word0_q;
    res_left_d   = res_left_q;
    res_right_d  = res_right_q;
    res_play_d   = res_play_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_left_d   = out_left_q;
    out_right_d  = out_right_q;
    out_play_d   = out_play_q;
    in_i.ready   = 1'b0;
    ram_we       = 1'b0;
    rem_start    = 1'b0;
    rem_dividend = tot;
    mix_start    = 1'b0;

    unique case (state_q)
      spv_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.func == spv_pkg::FUNC_LOAD) begin
            ram_we = (load_addr < DW'(SAMPLE_DEPTH));
          end else begin
            ctl_d       = in_i.speed_control;
            pan_d       = in_i.pan;
            res_left_d  = '0;
            res_right_d = '0;
            res_play_d  = 1'b0;
            if (in_i.play_level < spv_pkg::PLAY_STOP) begin
              pos_d   = '0;
              state_d = spv_pkg::ST_EMIT;
            end else if (in_i.play_level <= spv_pkg::PLAY_RUN) begin
              state_d = spv_pkg::ST_EMIT;
            end else if (looping_q) begin
              rem_start    = 1'b1;
              rem_dividend = DW'(pos_q);
              state_d      = spv_pkg::ST_MOD;
            end else if (DW'(pos_q) >= last) begin
              state_d = spv_pkg::ST_EMIT;
            end else begin
              cur_d   = pos_q;
              nxt_d   = pos_q + POS_W'(1);
              state_d = spv_pkg::ST_RD0;
            end
          end
        end
      end
      spv_pkg::ST_MOD: begin
        if (rem_done) begin
          cur_d   = rem_val[POS_W-1:0];
          nxt_d   = (rem_inc == count) ? '0 : rem_inc[POS_W-1:0];
          state_d = spv_pkg::ST_RD0;
        end
      end
      spv_pkg::ST_RD0: begin
        state_d = spv_pkg::ST_RD1;
      end
      spv_pkg::ST_RD1: begin
        word0_d = ram_rdata;
        state_d = spv_pkg::ST_RD2;
      end
      spv_pkg::ST_RD2: begin
        mix_start = 1'b1;
        state_d   = spv_pkg::ST_MIX;
      end
      spv_pkg::ST_MIX: begin
        if (mix_done) begin
          res_left_d  = mix_res.left;
          res_right_d = mix_res.right;
          res_play_d  = 1'b1;
          frac_d      = total[15:0];
          if (looping_q) begin
            rem_start = 1'b1;
            state_d   = spv_pkg::ST_WRAP;
          end else begin
            pos_d   = (tot > last) ? last[POS_W-1:0] : tot[POS_W-1:0];
            state_d = spv_pkg::ST_EMIT;
          end
        end
      end
      spv_pkg::ST_WRAP: begin
        if (rem_done) begin
          pos_d   = rem_val[POS_W-1:0];
          state_d = spv_pkg::ST_EMIT;
        end
      end
      spv_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_left_d  = res_left_q;
          out_right_d = res_right_q;
          out_play_d  = res_play_q;
          state_d     = spv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spv_pkg::ST_IDLE;
      pos_q       <= '0;
      frac_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      frac_q      <= frac_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    nxt_q       <= nxt_d;
    ctl_q       <= ctl_d;
    pan_q       <= pan_d;
    word0_q     <= word0_d;
    res_left_q  <= res_left_d;
    res_right_q <= res_right_d;
    res_play_q  <= res_play_d;
    out_left_q  <= out_left_d;
    out_right_q <= out_right_d;
    out_play_q  <= out_play_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_left_q;
  assign out_o.out_right = out_right_q;
  assign out_o.playing   = out_play_q;

endmodule

### rtl/spv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/spv_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module spv_rem #(
  parameter int W = 15
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  div_q;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic [W-1:0]  rem_n;

  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, div_q};
    rem_n = diff[W] ? trial[W-1:0] : diff[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], 1'b0};
      rem_q <= rem_n;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### rtl/spv_mix.sv
// Shared-multiplier sequencer: speed, panning and linear blend of two frames.
module spv_mix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  spv_pkg::mix_req_t req_i,
  output logic              done_o,
  output spv_pkg::mix_res_t res_o
);

  spv_pkg::mix_step_e step_q;
  logic               busy_q;
  logic               done_q;

  // operands latched at start
  logic [15:0]        x1_q, x2_q, y1_q, y2_q;
  logic [16:0]        gl_q, gr_q;
  logic [15:0]        frac_q;
  logic [16:0]        inv_frac_q;
  logic signed [24:0] diff_q;
  logic [15:0]        ctl_q;
  logic [23:0]        min_q;
  logic               stereo_out_q;

  logic [15:0]        px1_q, px2_q, py1_q, py2_q;
  logic signed [42:0] prod_q;
  logic signed [42:0] acc_q;
  logic [23:0]        speed_q;
  logic [15:0]        left_q, right_q;

  // start-time decode
  logic [15:0]        l1, r1, l2, r2;
  logic               pan_mode;
  logic signed [17:0] pan18;
  logic signed [17:0] gl_s, gr_s;

  always_comb begin
    l1       = spv_pkg::decode_half(req_i.word0[15:0], req_i.wide);
    r1       = spv_pkg::decode_half(req_i.word0[31:16], req_i.wide);
    l2       = spv_pkg::decode_half(req_i.word1[15:0], req_i.wide);
    r2       = spv_pkg::decode_half(req_i.word1[31:16], req_i.wide);
    pan_mode = req_i.stereo_out && !req_i.stereo_src;
    pan18    = {{2{req_i.pan[15]}}, req_i.pan};
    gl_s     = $signed({1'b0, spv_pkg::UNITY_GAIN}) - pan18;
    gr_s     = $signed({1'b0, spv_pkg::UNITY_GAIN}) + pan18;
  end

  // multiplier operand select
  logic signed [24:0] a_op;
  logic signed [17:0] b_op;
  logic signed [42:0] prod_d;
  logic signed [42:0] sum;
  logic signed [27:0] spd_sum;

  always_comb begin
    a_op = '0;
    b_op = '0;
    case (step_q)
      spv_pkg::MS_SPEED: begin
        a_op = diff_q;
        b_op = $signed({2'b00, ctl_q});
      end
      spv_pkg::MS_PAN_X1: begin
        a_op = 25'(signed'(x1_q));
        b_op = $signed({1'b0, gl_q});
      end
      spv_pkg::MS_PAN_X2: begin
        a_op = 25'(signed'(x2_q));
        b_op = $signed({1'b0, gl_q});
      end
      spv_pkg::MS_PAN_Y1: begin
        a_op = 25'(signed'(y1_q));
        b_op = $signed({1'b0, gr_q});
      end
      spv_pkg::MS_PAN_Y2: begin
        a_op = 25'(signed'(y2_q));
        b_op = $signed({1'b0, gr_q});
      end
      spv_pkg::MS_MIX_X1: begin
        a_op = 25'(signed'(px1_q));
        b_op = $signed({1'b0, inv_frac_q});
      end
      spv_pkg::MS_MIX_X2: begin
        a_op = 25'(signed'(px2_q));
        b_op = $signed({2'b00, frac_q});
      end
      spv_pkg::MS_MIX_Y1: begin
        a_op = 25'(signed'(py1_q));
        b_op = $signed({1'b0, inv_frac_q});
      end
      spv_pkg::MS_MIX_Y2: begin
        a_op = 25'(signed'(py2_q));
        b_op = $signed({2'b00, frac_q});
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
    prod_d  = a_op * b_op;
    sum     = acc_q + prod_q;
    spd_sum = $signed({4'b0000, min_q}) + 28'($signed(prod_q[42:16]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= spv_pkg::MS_SPEED;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= spv_pkg::MS_SPEED;
    end else if (busy_q) begin
      if (step_q == spv_pkg::MS_FLUSH) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= spv_pkg::mix_step_e'(step_q + 4'd1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // each step also retires the product issued one step earlier
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (start_i) begin
      x1_q         <= (!req_i.stereo_out && req_i.stereo_src) ? spv_pkg::avg2(l1, r1) : l1;
      x2_q         <= (!req_i.stereo_out && req_i.stereo_src) ? spv_pkg::avg2(l2, r2) : l2;
      y1_q         <= (req_i.stereo_out && req_i.stereo_src) ? r1 : l1;
      y2_q         <= (req_i.stereo_out && req_i.stereo_src) ? r2 : l2;
      gl_q         <= (pan_mode && !req_i.pan[15]) ? gl_s[16:0] : spv_pkg::UNITY_GAIN;
      gr_q         <= (pan_mode && req_i.pan[15]) ? gr_s[16:0] : spv_pkg::UNITY_GAIN;
      frac_q       <= req_i.frac;
      inv_frac_q   <= spv_pkg::UNITY_BLEND - {1'b0, req_i.frac};
      diff_q       <= $signed({1'b0, req_i.max_speed}) - $signed({1'b0, req_i.min_speed});
      ctl_q        <= req_i.ctl;
      min_q        <= req_i.min_speed;
      stereo_out_q <= req_i.stereo_out;
    end else if (busy_q) begin
      case (step_q)
        spv_pkg::MS_PAN_X1: speed_q <= spd_sum[27] ? '0 : spd_sum[23:0];
        spv_pkg::MS_PAN_X2: px1_q   <= prod_q[30:15];
        spv_pkg::MS_PAN_Y1: px2_q   <= prod_q[30:15];
        spv_pkg::MS_PAN_Y2: py1_q   <= prod_q[30:15];
        spv_pkg::MS_MIX_X1: py2_q   <= prod_q[30:15];
        spv_pkg::MS_MIX_X2: acc_q   <= prod_q;
        spv_pkg::MS_MIX_Y1: left_q  <= sum[31:16];
        spv_pkg::MS_MIX_Y2: acc_q   <= prod_q;
        spv_pkg::MS_FLUSH:  right_q <= sum[31:16];
        default: ;
      endcase
    end
  end

  assign done_o      = done_q;
  assign res_o.speed = speed_q;
  assign res_o.left  = left_q;
  assign res_o.right = stereo_out_q ? right_q : left_q;

endmodule

### tb/tb_sample_playback_voice.sv
// Self-checking testbench for the sample playback voice, with a built-in predictor.
module tb_sample_playback_voice;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_DEPTH = 16384;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 50;
  // low store words written up front; larger counts run slowly so reads stay inside them
  localparam int PRELOAD_WORDS = 256;
  localparam int SLOW_SPEED = 262143;
  localparam logic FUNC_TICK = ~spv_pkg::FUNC_LOAD;
  localparam logic [spv_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic               func;
    logic [13:0]        load_address;
    logic [15:0]        load_left;
    logic [15:0]        load_right;
    logic [7:0]         play_level;
    logic [15:0]        speed_control;
    logic signed [15:0] pan;
  } voice_item_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               playing;
  } voice_frame_t;

  typedef struct packed {
    logic                           is_reg;
    logic [spv_pkg::CFG_IDX_W-1:0]  idx;
    logic [spv_pkg::CFG_DATA_W-1:0] val;
    voice_item_t                    it;
    logic                           typed;
    voice_frame_t                   want;
  } step_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [spv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [spv_pkg::CFG_DATA_W-1:0] cfg_data;

  spv_in_if  beat_in ();
  spv_out_if frame_out ();

  sample_playback_voice #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (beat_in),
    .out_o      (frame_out),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // predictor state and register copy
  logic [31:0] store_m [SAMPLE_DEPTH];
  int          pos_m;
  int          frac_m;
  logic [14:0] count_cfg;
  logic        loop_cfg;
  logic        stereo_src_cfg;
  logic        stereo_out_cfg;
  logic        wide_cfg;
  logic [23:0] min_cfg;
  logic [23:0] max_cfg;

  voice_frame_t frame_q [$];
  int           fails;
  int           burst_left;
  bit           squeeze_req;

  wire in_acc  = beat_in.valid && beat_in.ready;
  wire out_acc = frame_out.valid && frame_out.ready;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int half_value(input logic [15:0] h);
    if (wide_cfg) begin
      return int'($signed(h));
    end
    return (int'(h[7:0]) - 128) * 256;
  endfunction

  function automatic int blend(input int a, input int b, input int f);
    longint acc;
    acc = longint'(a) * longint'(65536 - f) + longint'(b) * longint'(f);
    return int'(acc >>> 16);
  endfunction

  function automatic int pan_scale(input int s, input int g);
    return int'((longint'(s) * longint'(g)) >>> 15);
  endfunction

  function automatic voice_frame_t play_tick(input voice_item_t it);
    voice_frame_t fr;
    int n, last, p, q, pn, gl, gr, l1, r1, l2, r2, ol, orr;
    longint spd, tot;
    fr = '0;
    n = (count_cfg == 15'd0) ? 1 : int'(count_cfg);
    if (n > SAMPLE_DEPTH) n = SAMPLE_DEPTH;
    last = n - 1;
    if (it.play_level < spv_pkg::PLAY_STOP) begin
      pos_m = 0;
      return fr;
    end
    if (it.play_level <= spv_pkg::PLAY_RUN) return fr;
    p = pos_m;
    if (loop_cfg) begin
      p = p % n;
      q = (p + 1) % n;
    end else begin
      if (p >= last) return fr;
      q = p + 1;
    end
    spd = longint'(min_cfg) +
          (((longint'(max_cfg) - longint'(min_cfg)) * longint'(it.speed_control)) >>> 16);
    if (spd < 0) spd = 0;
    l1 = half_value(store_m[p][15:0]);
    r1 = half_value(store_m[p][31:16]);
    l2 = half_value(store_m[q][15:0]);
    r2 = half_value(store_m[q][31:16]);
    if (!stereo_out_cfg) begin
      if (stereo_src_cfg) begin
        l1 = (l1 + r1) >>> 1;
        l2 = (l2 + r2) >>> 1;
      end
      ol = blend(l1, l2, frac_m);
      orr = ol;
    end else if (stereo_src_cfg) begin
      ol = blend(l1, l2, frac_m);
      orr = blend(r1, r2, frac_m);
    end else begin
      pn = int'($signed(it.pan));
      gl = 32768 - pn;
      gr = 32768 + pn;
      if (gl > 32768) gl = 32768;
      if (gr > 32768) gr = 32768;
      ol = blend(pan_scale(l1, gl), pan_scale(l2, gl), frac_m);
      orr = blend(pan_scale(l1, gr), pan_scale(l2, gr), frac_m);
    end
    tot = longint'(frac_m) + spd;
    frac_m = int'(tot[15:0]);
    tot = (tot >>> 16) + longint'(p);
    if (loop_cfg) begin
      pos_m = int'(tot % longint'(n));
    end else begin
      pos_m = (tot > longint'(last)) ? last : int'(tot);
    end
    fr.left = ol[15:0];
    fr.right = orr[15:0];
    fr.playing = 1'b1;
    return fr;
  endfunction

  function automatic voice_frame_t voice_step(input voice_item_t it);
    if (it.func == spv_pkg::FUNC_LOAD) begin
      store_m[it.load_address] = {it.load_right, it.load_left};
      return '0;
    end
    return play_tick(it);
  endfunction

  function automatic voice_item_t noise_item();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return voice_item_t'(r[86:0]);
  endfunction

  function automatic voice_item_t random_item();
    voice_item_t it;
    int roll;
    it = noise_item();
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      it.func = spv_pkg::FUNC_LOAD;
    end else begin
      it.func = FUNC_TICK;
      if (roll < 23) it.play_level = 8'($urandom_range(0, 63));
      else if (roll < 30) it.play_level = 8'($urandom_range(64, 192));
      else it.play_level = 8'($urandom_range(193, 255));
    end
    return it;
  endfunction

  function automatic step_row_t row_reg(input logic [spv_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [spv_pkg::CFG_DATA_W-1:0] val);
    step_row_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  function automatic step_row_t row_load(input logic [13:0] a, input logic [15:0] l,
                                         input logic [15:0] r);
    step_row_t s;
    s = '0;
    s.it = noise_item();
    s.it.func = spv_pkg::FUNC_LOAD;
    s.it.load_address = a;
    s.it.load_left = l;
    s.it.load_right = r;
    return s;
  endfunction

  function automatic step_row_t row_tick(input logic [7:0] play, input logic [15:0] ctl,
                                         input logic signed [15:0] pn);
    step_row_t s;
    s = '0;
    s.it = noise_item();
    s.it.func = FUNC_TICK;
    s.it.play_level = play;
    s.it.speed_control = ctl;
    s.it.pan = pn;
    return s;
  endfunction

  function automatic step_row_t row_frame(input logic [7:0] play,
                                          input logic signed [15:0] l,
                                          input logic signed [15:0] r);
    step_row_t s;
    s = row_tick(play, 16'($urandom), 16'($urandom));
    s.typed = 1'b1;
    s.want = '{left: l, right: r, playing: 1'b1};
    return s;
  endfunction

  function automatic step_row_t row_quiet(input logic [7:0] play);
    step_row_t s;
    s = row_tick(play, 16'($urandom), 16'($urandom));
    s.typed = 1'b1;
    return s;
  endfunction

  function automatic logic [23:0] pick_speed();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom);
      default: return 24'($urandom_range(0, 196608));
    endcase
  endfunction

  task automatic send(input voice_item_t it, input bit typed, input voice_frame_t want);
    voice_frame_t got;
    beat_in.valid         <= 1'b1;
    beat_in.func          <= it.func;
    beat_in.load_address  <= it.load_address;
    beat_in.load_left     <= it.load_left;
    beat_in.load_right    <= it.load_right;
    beat_in.play_level    <= it.play_level;
    beat_in.speed_control <= it.speed_control;
    beat_in.pan           <= it.pan;
    do @(posedge clk_i); while (!beat_in.ready);
    got = voice_step(it);
    if (it.func != spv_pkg::FUNC_LOAD) frame_q.push_back(typed ? want : got);
  endtask

  task automatic offer(input voice_item_t it, input bit typed, input voice_frame_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        beat_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    send(it, typed, want);
    burst_left--;
  endtask

  // quiet the input, let every frame out and give the sequencer time to go idle
  task automatic settle();
    beat_in.valid <= 1'b0;
    burst_left = 0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [spv_pkg::CFG_IDX_W-1:0] idx,
                         input logic [spv_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      spv_pkg::CFG_SAMPLE_COUNT:  count_cfg = val[14:0];
      spv_pkg::CFG_LOOPING:       loop_cfg = val[0];
      spv_pkg::CFG_STEREO_SOURCE: stereo_src_cfg = val[0];
      spv_pkg::CFG_STEREO_OUTPUT: stereo_out_cfg = val[0];
      spv_pkg::CFG_WIDE_SAMPLES:  wide_cfg = val[0];
      spv_pkg::CFG_MIN_SPEED:     min_cfg = val;
      spv_pkg::CFG_MAX_SPEED:     max_cfg = val;
      default: ;
    endcase
  endtask

  // receiver: stall patterns of varying density, plus one long hold-off on request
  initial begin : frame_sink
    bit squeezed;
    int mode;
    squeezed = 1'b0;
    frame_out.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        frame_out.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        repeat ($urandom_range(8, 64)) begin
          case (mode)
            0: frame_out.ready <= 1'b1;
            1: frame_out.ready <= ($urandom_range(0, 3) != 0);
            default: frame_out.ready <= ($urandom_range(0, 2) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : frame_check
    voice_frame_t w;
    if (out_acc) begin
      if (frame_q.size() == 0) begin
        $error("unexpected frame: out_left %0d out_right %0d playing %0b",
               frame_out.out_left, frame_out.out_right, frame_out.playing);
        fails++;
      end else begin
        w = frame_q.pop_front();
        if (frame_out.out_left !== w.left) begin
          $error("out_left: expected %0d, got %0d", w.left, frame_out.out_left);
          fails++;
        end
        if (frame_out.out_right !== w.right) begin
          $error("out_right: expected %0d, got %0d", w.right, frame_out.out_right);
          fails++;
        end
        if (frame_out.playing !== w.playing) begin
          $error("playing: expected %0b, got %0b", w.playing, frame_out.playing);
          fails++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if (in_acc || out_acc) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    step_row_t steps [$];
    voice_item_t it;
    logic [14:0] cnt;
    fails = 0;
    burst_left = 0;
    squeeze_req = 1'b0;
    pos_m = 0;
    frac_m = 0;
    count_cfg = spv_pkg::RST_SAMPLE_COUNT;
    loop_cfg = 1'b0;
    stereo_src_cfg = 1'b0;
    stereo_out_cfg = 1'b0;
    wide_cfg = 1'b1;
    min_cfg = spv_pkg::RST_SPEED;
    max_cfg = spv_pkg::RST_SPEED;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    beat_in.valid <= 1'b0;
    beat_in.func <= spv_pkg::FUNC_LOAD;
    beat_in.load_address <= '0;
    beat_in.load_left <= '0;
    beat_in.load_right <= '0;
    beat_in.play_level <= '0;
    beat_in.speed_control <= '0;
    beat_in.pan <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every word a tick can reach gets a value before any tick reads it
    for (int a = 0; a < PRELOAD_WORDS; a++) begin
      it = noise_item();
      it.func = spv_pkg::FUNC_LOAD;
      it.load_address = 14'(a);
      send(it, 1'b0, '0);
    end

    steps = '{
      row_quiet(8'd255),
      row_quiet(8'd0),
      row_quiet(8'd128),
      row_load(14'd0, 16'h7FFF, 16'h8000),
      row_load(14'd1, 16'h8000, 16'h7FFF),
      row_load(14'd2, 16'h0000, 16'hFFFF),
      row_load(14'd16383, 16'hFFFF, 16'h0000),
      row_reg(spv_pkg::CFG_SAMPLE_COUNT, 24'd3),
      row_frame(8'd255, 16'sh7FFF, 16'sh7FFF),
      row_frame(8'd255, 16'sh8000, 16'sh8000),
      row_quiet(8'd255),
      row_quiet(8'd63),
      row_quiet(8'd64),
      row_quiet(8'd192),
      row_frame(8'd193, 16'sh7FFF, 16'sh7FFF),
      row_reg(spv_pkg::CFG_LOOPING, 24'd1),
      row_reg(spv_pkg::CFG_STEREO_SOURCE, 24'd1),
      row_reg(spv_pkg::CFG_STEREO_OUTPUT, 24'd1),
      row_reg(spv_pkg::CFG_MIN_SPEED, 24'd0),
      row_reg(spv_pkg::CFG_MAX_SPEED, 24'hFFFFFF),
      row_tick(8'd255, 16'hFFFF, 16'sh8000),
      row_tick(8'd255, 16'h0000, 16'sh7FFF),
      row_tick(8'd255, 16'h8000, 16'sh0000),
      row_reg(spv_pkg::CFG_STEREO_SOURCE, 24'd0),
      row_reg(spv_pkg::CFG_WIDE_SAMPLES, 24'd0),
      row_reg(spv_pkg::CFG_SAMPLE_COUNT, 24'd0),
      row_tick(8'd255, 16'hFFFF, 16'sh8000),
      row_tick(8'd255, 16'h1234, 16'sh7FFF),
      row_reg(spv_pkg::CFG_SAMPLE_COUNT, 24'h007FFF),
      row_reg(spv_pkg::CFG_WIDE_SAMPLES, 24'd1),
      row_reg(spv_pkg::CFG_MAX_SPEED, 24'h030000),
      row_tick(8'd255, 16'h0F0F, 16'sh1234),
      row_tick(8'd255, 16'hF0F0, 16'shEDCB),
      row_tick(8'd255, 16'h5555, 16'sh4000),
      row_reg(spv_pkg::CFG_SAMPLE_COUNT, 24'd5),
      row_tick(8'd255, 16'hAAAA, 16'shC000),
      row_reg(spv_pkg::CFG_LOOPING, 24'd0),
      row_reg(spv_pkg::CFG_SAMPLE_COUNT, 24'd16384),
      row_reg(spv_pkg::CFG_MIN_SPEED, 24'hFFFFFF),
      row_tick(8'd255, 16'h0001, 16'sh0001),
      row_reg(spv_pkg::CFG_SAMPLE_COUNT, 24'd4),
      row_quiet(8'd255),
      row_reg(CFG_SPARE, 24'hFFFFFF),
      row_quiet(8'd255),
      row_reg(spv_pkg::CFG_STEREO_OUTPUT, 24'd0),
      row_reg(spv_pkg::CFG_STEREO_SOURCE, 24'd1),
      row_reg(spv_pkg::CFG_MIN_SPEED, 24'd3),
      row_reg(spv_pkg::CFG_MAX_SPEED, 24'd0),
      row_quiet(8'd0),
      row_tick(8'd255, 16'hFFFF, 16'sh0000),
      row_tick(8'd255, 16'h0000, 16'sh0000)
    };

    foreach (steps[k]) begin
      if (steps[k].is_reg) begin
        settle();
        set_reg(steps[k].idx, steps[k].val);
      end else begin
        offer(steps[k].it, steps[k].typed, steps[k].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 9))
        0: cnt = 15'd0;
        1: cnt = 15'h7FFF;
        2: cnt = 15'd16384;
        3: cnt = 15'($urandom_range(1, 16384));
        4: cnt = 15'd1;
        default: cnt = 15'($urandom_range(2, 48));
      endcase
      set_reg(spv_pkg::CFG_SAMPLE_COUNT, 24'(cnt));
      set_reg(spv_pkg::CFG_LOOPING, 24'($urandom_range(0, 1)));
      set_reg(spv_pkg::CFG_STEREO_SOURCE, 24'($urandom_range(0, 1)));
      set_reg(spv_pkg::CFG_STEREO_OUTPUT, 24'($urandom_range(0, 1)));
      set_reg(spv_pkg::CFG_WIDE_SAMPLES, 24'($urandom_range(0, 1)));
      if (cnt > 15'(PRELOAD_WORDS)) begin
        set_reg(spv_pkg::CFG_MIN_SPEED, 24'($urandom_range(0, SLOW_SPEED)));
        set_reg(spv_pkg::CFG_MAX_SPEED, 24'($urandom_range(0, SLOW_SPEED)));
      end else begin
        set_reg(spv_pkg::CFG_MIN_SPEED, pick_speed());
        set_reg(spv_pkg::CFG_MAX_SPEED, pick_speed());
      end
      if ($urandom_range(0, 3) == 0) set_reg(CFG_SPARE, 24'($urandom));
      if (ph == 3) squeeze_req = 1'b1;
      it = noise_item();
      it.func = FUNC_TICK;
      it.play_level = 8'($urandom_range(0, 63));
      offer(it, 1'b0, '0);
      repeat (PHASE_ITEMS) offer(random_item(), 1'b0, '0);
    end

    settle();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/spv_pkg.sv
rtl/spv_if.sv
rtl/spv_ram.sv
rtl/spv_rem.sv
rtl/spv_mix.sv
rtl/sample_playback_voice.sv
tb/tb_sample_playback_voice.sv
